// File: sv/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } ctrl_t;

endpackage

// File: sv/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell import spq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctrl_t  ctrl_i,
  input  logic   left_go_i,
  input  logic   left_vld_i,
  input  entry_t left_ent_i,
  input  logic   right_vld_i,
  input  entry_t right_ent_i,
  output logic   vld_o,
  output logic   go_o,
  output entry_t ent_o
);

  logic   vld_q, vld_d;
  entry_t ent_q, ent_d;
  logic   go;

  // New entry goes after this one when ours is equal or more urgent.
  assign go = vld_q && (ent_q.prio <= ctrl_i.ent.prio);

  always_comb begin
    vld_d = vld_q;
    ent_d = ent_q;
    if (ctrl_i.ins) begin
      if (!go) begin
        vld_d = left_vld_i;
        ent_d = left_go_i ? ctrl_i.ent : left_ent_i;
      end
    end else if (ctrl_i.rem) begin
      vld_d = right_vld_i;
      ent_d = right_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign vld_o = vld_q;
  assign go_o  = go;
  assign ent_o = ent_q;

endmodule

// File: sv/sorted_priority_queue.sv
// Top level of the bounded sorted priority queue built as a chain of cells.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command beat: insert
//   (item_value_i, item_priority_i) or remove the head entry. Lower priority
//   numbers are served first; equal priorities leave in arrival order.
//   Output channel (out_valid_o / out_ready_i) carries one result beat per
//   command: status, removed value and priority (zero unless removed), and the
//   occupancy after the command.
// Timing: the result beat is registered and is valid in the cycle after the command beat.
// Throughput: one command per cycle while results are taken. Every cell compares
//   its priority with the broadcast entry and shifts in the same cycle, so the
//   whole chain updates at once; the output register is the only stage.
// Reset: all cell valid bits and the entry count clear at once; the queue is
//   empty and ready as soon as reset is released.
// Stall: while a result beat waits on out_ready_i low, in_ready_o drops and
//   the chain holds; a command is taken in the same cycle the pending result
//   leaves.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned Capacity = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic signed [31:0] item_value_i,
  input  logic signed [15:0] item_priority_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_value_o,
  output logic signed [15:0] out_priority_o,
  output logic [4:0]         occupancy_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                full, empty, fire;
  ctrl_t               ctrl;
  logic [Capacity-1:0] cell_vld;
  logic [Capacity-1:0] cell_go;
  entry_t              cell_ent [Capacity];

  logic                out_valid_q;
  logic [1:0]          status_q, status_d;
  entry_t              res_q, res_d;
  logic [4:0]          occ_q;
  logic [CntW+4:0]     occ_wide;

  assign full       = (count_q == CntW'(Capacity));
  assign empty      = (count_q == '0);
  // Take a command whenever the result register is free or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign ctrl.ins       = fire && (command_i == CMD_INSERT) && !full;
  assign ctrl.rem       = fire && (command_i == CMD_REMOVE) && !empty;
  assign ctrl.ent.value = item_value_i;
  assign ctrl.ent.prio  = item_priority_i;

  // Chain: head at cell 0, tail at the last cell.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic   l_go, l_vld, r_vld;
    entry_t l_ent, r_ent;
    if (i == 0) begin : g_head
      assign l_go  = 1'b1;
      assign l_vld = 1'b1;
      assign l_ent = ctrl.ent;
    end else begin : g_mid
      assign l_go  = cell_go[i-1];
      assign l_vld = cell_vld[i-1];
      assign l_ent = cell_ent[i-1];
    end
    if (i == Capacity - 1) begin : g_tail
      assign r_vld = 1'b0;
      assign r_ent = '0;
    end else begin : g_inner
      assign r_vld = cell_vld[i+1];
      assign r_ent = cell_ent[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_go_i   (l_go),
      .left_vld_i  (l_vld),
      .left_ent_i  (l_ent),
      .right_vld_i (r_vld),
      .right_ent_i (r_ent),
      .vld_o       (cell_vld[i]),
      .go_o        (cell_go[i]),
      .ent_o       (cell_ent[i])
    );
  end

  // Result of the command taken this cycle.
  always_comb begin
    count_d  = count_q;
    status_d = ST_INSERTED;
    res_d    = '0;
    if (command_i == CMD_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else begin
        status_d = ST_REMOVED;
        res_d    = cell_ent[0];
        count_d  = count_q - CntW'(1);
      end
    end
  end

  // Occupancy reports the low five bits of the count.
  assign occ_wide = {5'b0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      res_q    <= res_d;
      occ_q    <= occ_wide[4:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_value_o    = res_q.value;
  assign out_priority_o = res_q.prio;
  assign occupancy_o    = occ_q;

`ifndef ASSERT_OFF
  a_vld_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_vld & (cell_vld + Capacity'(1))) == '0)
    else $error("cell valid bits are not a contiguous head prefix");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == int'(count_q))
    else $error("entry count disagrees with valid cells");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_vld[1] |-> (cell_ent[0].prio <= cell_ent[1].prio))
    else $error("head entry is not the most urgent");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("remove did not decrement the count");
`endif

endmodule
